@@ src/mtsa_pkg.sv @@
// Shared types and constants for the two-array merge block.
package mtsa_pkg;

    localparam int VAL_W = 64;
    localparam int CNT_W = 6;

    typedef enum logic [0:0] {
        REG_FIRST_COUNT  = 1'b0,
        REG_SECOND_COUNT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] nf;
        logic [CNT_W-1:0] ns;
        logic             clr;
    } cfg_t;

endpackage

@@ src/mtsa_in_if.sv @@
// Input channel: one value per item.
interface mtsa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mtsa_pkg::VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

@@ src/mtsa_out_if.sv @@
// Output channel: one merged element per item.
interface mtsa_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [mtsa_pkg::VAL_W-1:0] value_res;
    logic                                from_second;
    logic                                last;

    modport source (output valid, output value_res, output from_second, output last,
                    input ready);
    modport sink (input valid, input value_res, input from_second, input last,
                  output ready);
endinterface

@@ src/merge_two_sorted_arrays.sv @@
// Top level: count registers with clamping, and the merge sequencer.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      value (64b signed)
//  out_ch    out  valid/ready      value_res (64b signed), from_second, last
//  cfg       in   cfg_we           cfg_idx, cfg_wdata (6b)
//
// Loads accept one item per cycle. After the final load: a cross-swap over min(nf,ns)
// pairs, a bubble sort per store of max(1,len-1) passes, then each output item is read
// through the registered RAM read port before it is registered on the output.
// Input is not ready from the final load until the last output item is registered;
// a stalled output holds its item and pauses the emit sequence.
// Reset sets both count registers to one and clears the sequencer state; store contents are not cleared.
module merge_two_sorted_arrays #(
    parameter int MAX_FIRST  = 32,
    parameter int MAX_SECOND = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  mtsa_pkg::reg_idx_t            cfg_idx,
    input  logic [mtsa_pkg::CNT_W-1:0]    cfg_wdata,
    mtsa_in_if.sink                       in_ch,
    mtsa_out_if.source                    out_ch
);
    import mtsa_pkg::*;

    logic [CNT_W-1:0] first_count_reg, second_count_reg;
    cfg_t             cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= CNT_W'(1);
            second_count_reg <= CNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FIRST_COUNT:  first_count_reg  <= cfg_wdata;
                REG_SECOND_COUNT: second_count_reg <= cfg_wdata;
                default:          first_count_reg  <= first_count_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.clr = cfg_we;
        if (first_count_reg == '0)
        begin
            cfg.nf = CNT_W'(1);
        end
        else if (first_count_reg > CNT_W'(MAX_FIRST))
        begin
            cfg.nf = CNT_W'(MAX_FIRST);
        end
        else
        begin
            cfg.nf = first_count_reg;
        end
        if (second_count_reg == '0)
        begin
            cfg.ns = CNT_W'(1);
        end
        else if (second_count_reg > CNT_W'(MAX_SECOND))
        begin
            cfg.ns = CNT_W'(MAX_SECOND);
        end
        else
        begin
            cfg.ns = second_count_reg;
        end
    end

    mtsa_ctrl #(.MAX_FIRST(MAX_FIRST), .MAX_SECOND(MAX_SECOND)) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

@@ src/mtsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mtsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/mtsa_ctrl.sv @@
// Sequencer: load, cross-swap, bubble sort and emit over the two store RAMs.
module mtsa_ctrl #(
    parameter int MAX_FIRST  = 32,
    parameter int MAX_SECOND = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mtsa_pkg::cfg_t cfg,
    mtsa_in_if.sink        in_ch,
    mtsa_out_if.source     out_ch
);
    import mtsa_pkg::*;

    localparam int MAXN = (MAX_FIRST > MAX_SECOND) ? MAX_FIRST : MAX_SECOND;
    localparam int AWF  = (MAX_FIRST > 1) ? $clog2(MAX_FIRST) : 1;
    localparam int AWS  = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
    localparam int CW   = $clog2(MAXN + 2);
    localparam int LW   = $clog2(MAX_FIRST + MAX_SECOND + 1);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_CROSS = 5'b00010,
        S_SORT  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_EMITW = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       load_cnt_reg, load_cnt_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       pass_reg, pass_next;
    logic                sel_reg, sel_next;
    logic [VAL_W-1:0]    carry_reg, carry_next;
    logic                out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic                out_second_reg, out_second_next;
    logic                out_last_reg, out_last_next;

    logic                f_we, s_we;
    logic [CW-1:0]       f_wa, f_ra, s_wa, s_ra;
    logic [LW-1:0]       s_la;
    logic [VAL_W-1:0]    f_wd, s_wd, f_rd, s_rd, rd_sel, lo, hi;
    logic [CW-1:0]       nf, ns, lim, len;
    logic [LW-1:0]       total;
    logic                in_acc, rd_gt;

    assign nf     = CW'(cfg.nf);
    assign ns     = CW'(cfg.ns);
    assign lim    = (nf < ns) ? nf : ns;
    assign len    = sel_reg ? ns : nf;
    assign total  = LW'(cfg.nf) + LW'(cfg.ns);
    assign in_acc = in_ch.valid && in_ch.ready;
    assign s_la   = load_cnt_reg - LW'(cfg.nf);
    assign rd_sel = sel_reg ? s_rd : f_rd;
    assign rd_gt  = $signed(rd_sel) > $signed(carry_reg);
    assign lo     = rd_gt ? carry_reg : rd_sel;
    assign hi     = rd_gt ? rd_sel : carry_reg;

    assign in_ch.ready        = (state_reg == S_LOAD);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.value_res   = out_value_reg;
    assign out_ch.from_second = out_second_reg;
    assign out_ch.last        = out_last_reg;

    mtsa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_FIRST), .AW(AWF)) u_first (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_wa[AWF-1:0]),
        .wdata (f_wd),
        .raddr (f_ra[AWF-1:0]),
        .rdata (f_rd)
    );

    mtsa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SECOND), .AW(AWS)) u_second (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wa[AWS-1:0]),
        .wdata (s_wd),
        .raddr (s_ra[AWS-1:0]),
        .rdata (s_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        load_cnt_next   = load_cnt_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        sel_next        = sel_reg;
        carry_next      = carry_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_second_next = out_second_reg;
        out_last_next   = out_last_reg;
        f_we = 1'b0;
        s_we = 1'b0;
        f_wa = '0;
        s_wa = '0;
        f_ra = '0;
        s_ra = '0;
        f_wd = in_ch.value;
        s_wd = in_ch.value;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_cnt_reg < LW'(cfg.nf))
                    begin
                        f_we = 1'b1;
                        f_wa = CW'(load_cnt_reg);
                    end
                    else
                    begin
                        s_we = 1'b1;
                        s_wa = CW'(s_la);
                    end
                    if (load_cnt_reg + LW'(1) == total)
                    begin
                        load_cnt_next = '0;
                        idx_next      = '0;
                        state_next    = S_CROSS;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + LW'(1);
                    end
                end
                if (cfg.clr)
                begin
                    load_cnt_next = '0;
                end
            end
            S_CROSS:
            begin
                f_ra = nf - CW'(1) - idx_reg;
                s_ra = idx_reg;
                if (idx_reg != '0)
                begin
                    f_we = 1'b1;
                    s_we = 1'b1;
                    f_wa = nf - idx_reg;
                    s_wa = idx_reg - CW'(1);
                    if ($signed(f_rd) > $signed(s_rd))
                    begin
                        f_wd = s_rd;
                        s_wd = f_rd;
                    end
                    else
                    begin
                        f_wd = f_rd;
                        s_wd = s_rd;
                    end
                end
                if (idx_reg == lim)
                begin
                    idx_next   = '0;
                    pass_next  = '0;
                    sel_next   = 1'b0;
                    state_next = S_SORT;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_SORT:
            begin
                f_ra = idx_reg;
                s_ra = idx_reg;
                f_wd = lo;
                s_wd = lo;
                if (idx_reg == CW'(1))
                begin
                    carry_next = rd_sel;
                end
                else if (idx_reg >= CW'(2) && idx_reg <= len)
                begin
                    f_we       = !sel_reg;
                    s_we       = sel_reg;
                    f_wa       = idx_reg - CW'(2);
                    s_wa       = idx_reg - CW'(2);
                    carry_next = hi;
                end
                if (idx_reg == len + CW'(1))
                begin
                    f_we = !sel_reg;
                    s_we = sel_reg;
                    f_wa = len - CW'(1);
                    s_wa = len - CW'(1);
                    f_wd = carry_reg;
                    s_wd = carry_reg;
                    idx_next = '0;
                    if (pass_reg + CW'(1) >= len - CW'(1))
                    begin
                        pass_next = '0;
                        if (sel_reg)
                        begin
                            sel_next   = 1'b0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            sel_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pass_next = pass_reg + CW'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                f_ra = idx_reg;
                s_ra = idx_reg;
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_EMITW;
                end
            end
            S_EMITW:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rd_sel;
                out_second_next = sel_reg;
                out_last_next   = sel_reg && (idx_reg + CW'(1) == len);
                state_next      = S_EMIT;
                if (idx_reg + CW'(1) == len)
                begin
                    idx_next = '0;
                    sel_next = !sel_reg;
                    if (sel_reg)
                    begin
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            idx_reg       <= '0;
            pass_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            idx_reg       <= idx_next;
            pass_reg      <= pass_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg      <= carry_next;
        out_value_reg  <= out_value_next;
        out_second_reg <= out_second_next;
        out_last_reg   <= out_last_next;
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for merge_two_sorted_arrays: random loads, predicted merge, checker.
module tb;
    import mtsa_pkg::*;

    localparam int MAX_FIRST    = 32;
    localparam int MAX_SECOND   = 32;
    localparam int ITEMS        = 420;
    localparam int SETTLE       = 8;
    localparam int RX_HOLD      = 400;
    localparam int STALL_LIMIT  = 20000;

    typedef logic signed [VAL_W-1:0] word_t;
    typedef word_t bank_t [MAX_FIRST > MAX_SECOND ? MAX_FIRST : MAX_SECOND];

    typedef struct packed {
        word_t value;
        logic  from_second;
        logic  last;
    } merged_t;

    localparam word_t W_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    reg_idx_t         cfg_idx;
    logic [CNT_W-1:0] cfg_wdata;

    mtsa_in_if  in_ch ();
    mtsa_out_if out_ch ();

    merge_two_sorted_arrays #(
        .MAX_FIRST  (MAX_FIRST),
        .MAX_SECOND (MAX_SECOND)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    bank_t            first_bank;
    bank_t            second_bank;
    int               load_pos;
    logic [CNT_W-1:0] first_cnt;
    logic [CNT_W-1:0] second_cnt;

    word_t   value_feed [$];
    merged_t merged_due [$];
    int      pushed;
    int      loads_taken;
    int      errors;
    int      idle_cycles;
    int      in_gap;
    int      rx_wait;
    bit      in_gaps_on;
    bit      out_gaps_on;
    bit      hold_go;
    logic    rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int eff_count(logic [CNT_W-1:0] c, int maxc);
        if (c == 0)
            return 1;
        if (c > maxc)
            return maxc;
        return int'(c);
    endfunction

    function automatic bank_t sort_bank(bank_t b, int len);
        word_t key;
        int    j;
        for (int a = 1; a < len; a++)
        begin
            key = b[a];
            j = a;
            while (j > 0 && b[j-1] > key)
            begin
                b[j] = b[j-1];
                j--;
            end
            b[j] = key;
        end
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CNT_W'($urandom_range(1, 6));
        if (r < 75)
            return CNT_W'($urandom_range(7, 16));
        if (r < 85)
            return CNT_W'(MAX_FIRST);
        if (r < 90)
            return '0;
        if (r < 95)
            return CNT_W'($urandom_range(33, 63));
        return CNT_W'($urandom_range(17, 31));
    endfunction

    function automatic word_t gen_word(int mode);
        int s;
        case (mode)
            0: return {$urandom, $urandom};
            1:
            begin
                s = int'($urandom_range(0, 40)) - 20;
                return word_t'(s);
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return W_MIN;
                    1: return W_MAX;
                    2: return '0;
                    3: return '1;
                    4: return W_MIN + 1;
                    default: return W_MAX - 1;
                endcase
            end
        endcase
    endfunction

    // one accepted load; queues the merged elements when it completes a run
    function automatic void merge_step(word_t v);
        int      nf;
        int      ns;
        int      tot;
        int      lim;
        int      i;
        word_t   t;
        merged_t r;
        nf  = eff_count(first_cnt, MAX_FIRST);
        ns  = eff_count(second_cnt, MAX_SECOND);
        tot = nf + ns;
        if (load_pos >= tot)
            load_pos = 0;
        if (load_pos < nf)
            first_bank[load_pos] = v;
        else
            second_bank[load_pos - nf] = v;
        load_pos++;
        if (load_pos < tot)
            return;
        load_pos = 0;
        lim = nf < ns ? nf : ns;
        for (int k = 0; k < lim; k++)
        begin
            i = nf - 1 - k;
            if (first_bank[i] > second_bank[k])
            begin
                t = first_bank[i];
                first_bank[i] = second_bank[k];
                second_bank[k] = t;
            end
        end
        first_bank  = sort_bank(first_bank, nf);
        second_bank = sort_bank(second_bank, ns);
        for (int k = 0; k < nf; k++)
        begin
            r.value       = first_bank[k];
            r.from_second = 1'b0;
            r.last        = (k == tot - 1);
            merged_due.push_back(r);
        end
        for (int k = 0; k < ns; k++)
        begin
            r.value       = second_bank[k];
            r.from_second = 1'b1;
            r.last        = (nf + k == tot - 1);
            merged_due.push_back(r);
        end
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_gap      <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                merge_step(in_ch.value);
                loads_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap      <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (value_feed.size() != 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.value <= value_feed.pop_front();
                    in_gap      <= in_gaps_on ? pick_gap() : 0;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        merged_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_wait      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (merged_due.size() == 0)
                    flag_error($sformatf("unexpected item value %0d from_second %0b last %0b",
                                         out_ch.value_res, out_ch.from_second, out_ch.last));
                else
                begin
                    want = merged_due.pop_front();
                    if (out_ch.value_res !== want.value
                        || out_ch.from_second !== want.from_second
                        || out_ch.last !== want.last)
                        flag_error($sformatf(
                            "mismatch exp/got value %0d/%0d from_second %0b/%0b last %0b/%0b",
                            want.value, out_ch.value_res, want.from_second,
                            out_ch.from_second, want.last, out_ch.last));
                end
            end
            if (rx_hold)
                out_ch.ready <= 1'b0;
            else if (rx_wait != 0)
            begin
                rx_wait      <= rx_wait - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (out_gaps_on && $urandom_range(0, 2) == 0)
                    rx_wait <= pick_gap();
            end
        end
    end

    // long receiver hold-off while loads keep coming
    initial
    begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CNT_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FIRST_COUNT)
            first_cnt = v;
        else
            second_cnt = v;
        load_pos = 0;
    endtask

    task automatic wait_drained();
        while (loads_taken != pushed || merged_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_word(word_t v);
        value_feed.push_back(v);
        pushed++;
    endtask

    task automatic queue_run(bit ordered);
        bank_t a;
        bank_t b;
        int    nf;
        int    ns;
        int    mode;
        nf   = eff_count(first_cnt, MAX_FIRST);
        ns   = eff_count(second_cnt, MAX_SECOND);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < nf; i++)
            a[i] = gen_word(mode);
        for (int i = 0; i < ns; i++)
            b[i] = gen_word(mode);
        if (ordered)
        begin
            a = sort_bank(a, nf);
            b = sort_bank(b, ns);
        end
        for (int i = 0; i < nf; i++)
            queue_word(a[i]);
        for (int i = 0; i < ns; i++)
            queue_word(b[i]);
    endtask

    initial
    begin
        logic [CNT_W-1:0] fc;
        logic [CNT_W-1:0] sc;
        int               runs;
        int               tot;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = REG_FIRST_COUNT;
        cfg_wdata    = '0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        hold_go      = 1'b0;
        in_gaps_on   = 1'b1;
        out_gaps_on  = 1'b1;
        first_cnt    = CNT_W'(1);
        second_cnt   = CNT_W'(1);
        load_pos     = 0;
        pushed       = 0;
        loads_taken  = 0;
        errors       = 0;
        idle_cycles  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset counts: one element each; swap, no swap, equal
        queue_word(W_MAX);
        queue_word(W_MIN);
        queue_word(W_MIN);
        queue_word(W_MAX);
        queue_word('1);
        queue_word('1);
        wait_drained();

        // zero count behaves as one
        write_reg(REG_FIRST_COUNT, '0);
        write_reg(REG_SECOND_COUNT, CNT_W'(2));
        queue_word(word_t'(7));
        queue_word(word_t'(-3));
        queue_word(word_t'(7));
        wait_drained();

        // partial run abandoned by a register write
        write_reg(REG_FIRST_COUNT, CNT_W'(3));
        queue_word(word_t'(100));
        queue_word(word_t'(200));
        wait_drained();
        write_reg(REG_SECOND_COUNT, CNT_W'(2));
        queue_word(word_t'(-5));
        queue_word(word_t'(4));
        queue_word(word_t'(9));
        queue_word(word_t'(0));
        queue_word(word_t'(6));
        wait_drained();

        for (int phase = 0; pushed < ITEMS; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    fc = CNT_W'(32);
                    sc = CNT_W'(32);
                end
                1:
                begin
                    fc = CNT_W'(63);
                    sc = CNT_W'(0);
                end
                2:
                begin
                    fc = CNT_W'(0);
                    sc = CNT_W'(33);
                end
                3:
                begin
                    fc = CNT_W'(2);
                    sc = CNT_W'(3);
                end
                default:
                begin
                    fc = pick_count();
                    sc = pick_count();
                end
            endcase
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_FIRST_COUNT, fc);
                write_reg(REG_SECOND_COUNT, sc);
            end
            else
            begin
                write_reg(REG_SECOND_COUNT, sc);
                write_reg(REG_FIRST_COUNT, fc);
            end
            in_gaps_on  = $urandom_range(0, 3) != 0;
            out_gaps_on = $urandom_range(0, 3) != 0;
            tot  = eff_count(fc, MAX_FIRST) + eff_count(sc, MAX_SECOND);
            runs = 1 + $urandom_range(0, 48 / tot);
            if (phase == 3)
            begin
                in_gaps_on = 1'b0;
                runs       = 10;
                hold_go    = 1'b1;
            end
            for (int r = 0; r < runs; r++)
                queue_run($urandom_range(0, 4) != 0);
            if (tot > 1 && $urandom_range(0, 7) == 0)
                for (int i = $urandom_range(1, tot - 1); i > 0; i--)
                    queue_word(gen_word(0));
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && merged_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
